/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hdl/sha1sh_pkg.sv */
// Shared types, constants and round functions of the SHA-1 stream hasher.
// No dependencies; used by every module of the block.
package sha1sh_pkg;

    localparam int unsigned QDEPTH     = 2;
    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned NUM_ROUNDS = 80;
    localparam logic [2:0]  LAST_INDEX = 3'd4;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [5:0]  PAD_LIMIT  = 6'd56;

    localparam logic [31:0] IV [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // One queued work item: only items with a byte or an end mark are queued.
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       fin;
    } t_item;

    // Queue status seen by the front end.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20)      k = K0;
        else if (rnd < 7'd40) k = K1;
        else if (rnd < 7'd60) k = K2;
        else                  k = K3;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0]  rnd,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20)                      f = (b & c) | (~b & d);
        else if (rnd >= 7'd40 && rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                                  f = b ^ c ^ d;
        return f;
    endfunction

endpackage

/* hdl/sha1_stream_hasher.sv */
// SHA-1 stream hasher: one message byte per input transfer, five digest words
// out. The core absorbs a byte at a time; each full 64-byte block runs a
// compression (load, 80 rounds of the one round unit, final add). The
// end-of-message transfer is absorbed, then come one padding step and one
// compression (two, with a length step between them, when the length spills
// into an extra block) and the hand-out of the five digest words. A
// two-entry queue decouples the input port from the core, and the output
// register lets the core start on the next message while the last digest
// word waits. Depends on sha1sh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sha1_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] byte_present
    input  logic        i_s_tlast,   // end_of_message
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_tuser,   // [2:0] word_index
    output logic        o_m_tlast    // last_word
);

    sha1sh_pkg::t_item  push_item;
    sha1sh_pkg::t_item  head_item;
    sha1sh_pkg::t_qstat qstat;
    logic               push;
    logic               pop;
    logic               head_valid;
    logic [1:0]         q_level;

    sha1sh_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_item     (push_item)
    );

    sha1sh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_valid (head_valid),
        .o_stat  (qstat),
        .o_level (q_level)
    );

    sha1sh_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (head_valid),
        .i_item     (head_item),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    `ASSERT_IMPLY(a_level_bound, i_clk, i_rst_n, 1'b1, q_level <= 2'(sha1sh_pkg::QDEPTH))
    `ASSERT_IMPLY(a_index_range, i_clk, i_rst_n, o_m_tvalid, o_m_tuser <= sha1sh_pkg::LAST_INDEX)
    `ASSERT_IMPLY(a_last_tag, i_clk, i_rst_n, o_m_tvalid, o_m_tlast == (o_m_tuser == sha1sh_pkg::LAST_INDEX))
    `ASSERT_NEXT(a_word_order, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tvalid && (o_m_tuser == $past(o_m_tuser) + 3'd1))

endmodule

/* hdl/sha1sh_queue.sv */
// Two-entry register queue between the front end and the hashing core.
// Depends on sha1sh_pkg for the item and status types.
module sha1sh_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sha1sh_pkg::t_item  i_item,
    input  logic               i_pop,
    output sha1sh_pkg::t_item  o_item,
    output logic               o_valid,
    output sha1sh_pkg::t_qstat o_stat,
    output logic [1:0]         o_level
);

    sha1sh_pkg::t_item r_mem [sha1sh_pkg::QDEPTH];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              do_push;
    logic              do_pop;

    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign do_push = i_push && (r_cnt != 2'(sha1sh_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_valid      = (r_cnt != 2'd0);
    assign o_stat.full  = (r_cnt == 2'(sha1sh_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_level      = r_cnt;

endmodule

/* hdl/sha1sh_front.sv */
// Input side: takes stream transfers, drops idle items, queues the rest.
// Depends on sha1sh_pkg for the item and status types.
module sha1sh_front (
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,
    input  logic               i_s_tuser,
    input  logic               i_s_tlast,
    input  sha1sh_pkg::t_qstat i_qstat,
    output logic               o_push,
    output sha1sh_pkg::t_item  o_item
);

    // An item with neither a byte nor an end mark is taken and discarded.
    assign o_s_tready   = !i_qstat.full;
    assign o_item.data    = i_s_tdata;
    assign o_item.present = i_s_tuser;
    assign o_item.fin     = i_s_tlast;
    assign o_push       = i_s_tvalid && o_s_tready && (i_s_tuser || i_s_tlast);

endmodule

/* hdl/sha1sh_core.sv */
// Hashing core: absorbs bytes, pads, runs the 80-round compression and
// emits the digest words through an output register. Depends on sha1sh_pkg.
module sha1sh_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sha1sh_pkg::t_item i_item,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [31:0]       o_m_tdata,
    output logic [2:0]        o_m_tuser,
    output logic              o_m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_LEN,
        RET_EMIT
    } t_ret;

    t_state      r_state;
    t_ret        r_ret;
    logic [31:0] r_w [16];
    logic [31:0] r_h [sha1sh_pkg::NUM_WORDS];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [63:0] r_cnt;
    logic [6:0]  r_rnd;
    logic [2:0]  r_idx;
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic [2:0]  r_ouser;
    logic        r_olast;

    logic [63:0] n_cnt;
    logic [31:0] n_sched;
    logic [31:0] n_temp;
    logic [63:0] bit_len;
    logic        out_free;

    assign n_cnt    = r_cnt + 64'd1;
    assign n_sched  = {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} << 1
                    | {31'd0, r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};
    assign n_temp   = {r_a[26:0], r_a[31:27]} + sha1sh_pkg::round_f(r_rnd, r_b, r_c, r_d)
                    + r_e + sha1sh_pkg::round_k(r_rnd) + r_w[0];
    assign bit_len  = {r_cnt[60:0], 3'b000};
    assign out_free = !r_ovalid || i_m_tready;
    assign o_pop    = (r_state == S_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= RET_IDLE;
            r_cnt    <= 64'd0;
            r_rnd    <= 7'd0;
            r_idx    <= 3'd0;
            r_ovalid <= 1'b0;
            r_a      <= 32'd0;
            r_b      <= 32'd0;
            r_c      <= 32'd0;
            r_d      <= 32'd0;
            r_e      <= 32'd0;
            for (int i = 0; i < 16; i++) r_w[i] <= 32'd0;
            for (int i = 0; i < int'(sha1sh_pkg::NUM_WORDS); i++) r_h[i] <= sha1sh_pkg::IV[i];
        end else begin
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_item.present) begin
                            r_w[r_cnt[5:2]][8 * (3 - int'(r_cnt[1:0])) +: 8] <= i_item.data;
                            r_cnt <= n_cnt;
                            if (n_cnt[5:0] == 6'd0) begin
                                r_state <= S_LOAD;
                                r_ret   <= i_item.fin ? RET_PAD : RET_IDLE;
                            end else if (i_item.fin) begin
                                r_state <= S_PAD;
                            end
                        end else begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_w[r_cnt[5:2]][8 * (3 - int'(r_cnt[1:0])) +: 8] <= sha1sh_pkg::PAD_BYTE;
                    r_state <= S_LOAD;
                    if (r_cnt[5:0] >= sha1sh_pkg::PAD_LIMIT) begin
                        r_ret <= RET_LEN;
                    end else begin
                        // Pad byte sits at word 13 or below, so the length fits now.
                        r_w[14] <= bit_len[63:32];
                        r_w[15] <= bit_len[31:0];
                        r_ret   <= RET_EMIT;
                    end
                end
                S_LEN: begin
                    r_w[14] <= bit_len[63:32];
                    r_w[15] <= bit_len[31:0];
                    r_ret   <= RET_EMIT;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_a     <= r_h[0];
                    r_b     <= r_h[1];
                    r_c     <= r_h[2];
                    r_d     <= r_h[3];
                    r_e     <= r_h[4];
                    r_rnd   <= 7'd0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    // Schedule window shifts each round; r_w[0] is this round's word.
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= n_sched;
                    r_a     <= n_temp;
                    r_b     <= r_a;
                    r_c     <= {r_b[1:0], r_b[31:2]};
                    r_d     <= r_c;
                    r_e     <= r_d;
                    r_rnd   <= r_rnd + 7'd1;
                    if (r_rnd == 7'(sha1sh_pkg::NUM_ROUNDS - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    for (int i = 0; i < 16; i++) r_w[i] <= 32'd0;
                    case (r_ret)
                        RET_IDLE: r_state <= S_IDLE;
                        RET_PAD:  r_state <= S_PAD;
                        RET_LEN:  r_state <= S_LEN;
                        RET_EMIT: r_state <= S_EMIT;
                        default:  r_state <= S_IDLE;
                    endcase
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_h[r_idx];
                        r_ouser  <= r_idx;
                        r_olast  <= (r_idx == sha1sh_pkg::LAST_INDEX);
                        r_idx    <= r_idx + 3'd1;
                        if (r_idx == sha1sh_pkg::LAST_INDEX) begin
                            r_idx   <= 3'd0;
                            r_cnt   <= 64'd0;
                            r_state <= S_IDLE;
                            for (int i = 0; i < int'(sha1sh_pkg::NUM_WORDS); i++) begin
                                r_h[i] <= sha1sh_pkg::IV[i];
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

endmodule
